// ----- design/hic_pkg.sv -----
// Shared constants and types for the homography inlier check unit.
package hic_pkg;

  localparam int unsigned RegBits  = 63;
  localparam int unsigned ErrBits  = 16;
  localparam int unsigned IdxBits  = 2;

  localparam logic [IdxBits-1:0] RegRowOne   = 2'd0;
  localparam logic [IdxBits-1:0] RegRowTwo   = 2'd1;
  localparam logic [IdxBits-1:0] RegRowThree = 2'd2;
  localparam logic [IdxBits-1:0] RegMaxError = 2'd3;

  localparam logic [ErrBits-1:0] MaxErrorReset = 16'd64;

  // Numerator and denominator sums fit in 64 bits; the division takes 72 steps.
  localparam int unsigned SumBits  = 64;
  localparam int unsigned QuotBits = 51;
  localparam int unsigned DivSteps = 72;
  localparam int unsigned QuotShift = 18;
  localparam int unsigned NumShift  = 16;
  localparam int unsigned DenShift  = 18;

endpackage

// ----- design/hic_div_stage.sv -----
// One restoring-division step applied to both projections, with pass-through payload.
module hic_div_stage #(
  parameter int unsigned PayBits = 80,
  parameter int unsigned Step    = 71
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic                             ok_i,
  input  logic [hic_pkg::SumBits-1:0]      ad_i,
  input  logic [hic_pkg::SumBits-1:0]      anx_i,
  input  logic [hic_pkg::SumBits-1:0]      any_i,
  input  logic [hic_pkg::SumBits:0]        remx_i,
  input  logic [hic_pkg::SumBits:0]        remy_i,
  input  logic [hic_pkg::QuotBits-1:0]     quox_i,
  input  logic [hic_pkg::QuotBits-1:0]     quoy_i,
  input  logic [1:0]                       neg_i,
  input  logic [PayBits-1:0]               pay_i,
  output logic                             valid_o,
  output logic                             ok_o,
  output logic [hic_pkg::SumBits-1:0]      ad_o,
  output logic [hic_pkg::SumBits-1:0]      anx_o,
  output logic [hic_pkg::SumBits-1:0]      any_o,
  output logic [hic_pkg::SumBits:0]        remx_o,
  output logic [hic_pkg::SumBits:0]        remy_o,
  output logic [hic_pkg::QuotBits-1:0]     quox_o,
  output logic [hic_pkg::QuotBits-1:0]     quoy_o,
  output logic [1:0]                       neg_o,
  output logic [PayBits-1:0]               pay_o
);

  localparam int unsigned SB = hic_pkg::SumBits;
  localparam int unsigned QB = hic_pkg::QuotBits;

  logic              bitx, bity;
  logic [SB+1:0]     shx, shy;
  logic              gex, gey;
  logic [SB:0]       remx_d, remy_d;
  logic [QB-1:0]     quox_d, quoy_d;
  logic              ok_d;
  logic              valid_q, ok_q;
  logic [SB-1:0]     ad_q, anx_q, any_q;
  logic [SB:0]       remx_q, remy_q;
  logic [QB-1:0]     quox_q, quoy_q;
  logic [1:0]        neg_q;
  logic [PayBits-1:0] pay_q;

  always_comb begin
    if (Step >= hic_pkg::QuotShift) begin
      bitx = anx_i[(Step - hic_pkg::QuotShift) % SB];
      bity = any_i[(Step - hic_pkg::QuotShift) % SB];
    end else begin
      bitx = 1'b0;
      bity = 1'b0;
    end
    shx = {remx_i, bitx};
    shy = {remy_i, bity};
    gex = shx >= {2'b00, ad_i};
    gey = shy >= {2'b00, ad_i};
    remx_d = gex ? (SB+1)'(shx - {2'b00, ad_i}) : (SB+1)'(shx);
    remy_d = gey ? (SB+1)'(shy - {2'b00, ad_i}) : (SB+1)'(shy);
    // A quotient of 2^50 or more rejects the pair.
    ok_d = ok_i & ~quox_i[QB-1] & ~quoy_i[QB-1];
    quox_d = {quox_i[QB-2:0], gex};
    quoy_d = {quoy_i[QB-2:0], gey};
    ok_d = ok_d & ~quox_d[QB-1] & ~quoy_d[QB-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q   <= ok_d;
      ad_q   <= ad_i;
      anx_q  <= anx_i;
      any_q  <= any_i;
      remx_q <= remx_d;
      remy_q <= remy_d;
      quox_q <= quox_d;
      quoy_q <= quoy_d;
      neg_q  <= neg_i;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign ok_o    = ok_q;
  assign ad_o    = ad_q;
  assign anx_o   = anx_q;
  assign any_o   = any_q;
  assign remx_o  = remx_q;
  assign remy_o  = remy_q;
  assign quox_o  = quox_q;
  assign quoy_o  = quoy_q;
  assign neg_o   = neg_q;
  assign pay_o   = pay_q;

endmodule

// ----- design/homography_inlier_check_unit.sv -----
// Homography inlier check: project, divide, compare squared error, forward inliers.
// Pipeline: 3 arithmetic stages, 72 division stages, 2 compare stages and the output
// register.
// Throughput: one pair per cycle; the whole pipeline advances when the output
// register is empty or being taken, so only a waiting result stalls the input.
// Reset: coefficients clear to zero (every pair rejected), max_error goes to 64.
module homography_inlier_check_unit #(
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned COEF_BITS  = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [62:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] src_x_i,
  input  logic signed [COORD_BITS-1:0] src_y_i,
  input  logic signed [COORD_BITS-1:0] dst_x_i,
  input  logic signed [COORD_BITS-1:0] dst_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] in_src_x_o,
  output logic signed [COORD_BITS-1:0] in_src_y_o,
  output logic signed [COORD_BITS-1:0] in_dst_x_o,
  output logic signed [COORD_BITS-1:0] in_dst_y_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned KB  = COEF_BITS;
  localparam int unsigned SB  = hic_pkg::SumBits;
  localparam int unsigned QB  = hic_pkg::QuotBits;
  localparam int unsigned PB  = 4 * CB;
  localparam int unsigned NDS = hic_pkg::DivSteps;
  localparam int unsigned PRB = CB + KB;

  logic [62:0] row_one_q, row_two_q, row_three_q;
  logic [15:0] max_error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_one_q   <= '0;
      row_two_q   <= '0;
      row_three_q <= '0;
      max_error_q <= hic_pkg::MaxErrorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hic_pkg::RegRowOne:   row_one_q   <= cfg_data_i;
        hic_pkg::RegRowTwo:   row_two_q   <= cfg_data_i;
        hic_pkg::RegRowThree: row_three_q <= cfg_data_i;
        hic_pkg::RegMaxError: max_error_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [KB-1:0] h11, h12, h13, h21, h22, h23, h31, h32, h33;
  assign h11 = row_one_q[KB-1:0];
  assign h12 = row_one_q[2*KB-1:KB];
  assign h13 = row_one_q[3*KB-1:2*KB];
  assign h21 = row_two_q[KB-1:0];
  assign h22 = row_two_q[2*KB-1:KB];
  assign h23 = row_two_q[3*KB-1:2*KB];
  assign h31 = row_three_q[KB-1:0];
  assign h32 = row_three_q[2*KB-1:KB];
  assign h33 = row_three_q[3*KB-1:2*KB];

  // Whole pipeline advances together; the output register acts as the skid stage.
  logic en;
  logic out_valid_q;
  assign en = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // Stage 1: six products.
  logic                  v1_q;
  logic signed [PRB-1:0] p11_q, p12_q, p21_q, p22_q, p31_q, p32_q;
  logic signed [KB-1:0]  t13_q, t23_q, t33_q;
  logic [PB-1:0]         pay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p11_q  <= PRB'(h11 * src_x_i);
      p12_q  <= PRB'(h12 * src_y_i);
      p21_q  <= PRB'(h21 * src_x_i);
      p22_q  <= PRB'(h22 * src_y_i);
      p31_q  <= PRB'(h31 * src_x_i);
      p32_q  <= PRB'(h32 * src_y_i);
      t13_q  <= h13;
      t23_q  <= h23;
      t33_q  <= h33;
      pay1_q <= {src_x_i, src_y_i, dst_x_i, dst_y_i};
    end
  end

  // Stage 2: sums.
  logic                 v2_q;
  logic signed [SB-1:0] nx_q, ny_q, dn_q;
  logic [PB-1:0]        pay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= SB'(p11_q) + SB'(p12_q)
              + (SB'(t13_q) <<< hic_pkg::NumShift);
      ny_q <= SB'(p21_q) + SB'(p22_q)
              + (SB'(t23_q) <<< hic_pkg::NumShift);
      dn_q <= SB'(p31_q) + SB'(p32_q)
              + (SB'(t33_q) <<< hic_pkg::DenShift);
      pay2_q <= pay1_q;
    end
  end

  // Stage 3: magnitudes and signs.
  logic          v3_q, ok3_q;
  logic [SB-1:0] anx_q, any_q, ad_q;
  logic [1:0]    neg3_q;
  logic [PB-1:0] pay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      anx_q  <= nx_q[SB-1] ? SB'(-nx_q) : SB'(nx_q);
      any_q  <= ny_q[SB-1] ? SB'(-ny_q) : SB'(ny_q);
      ad_q   <= dn_q[SB-1] ? SB'(-dn_q) : SB'(dn_q);
      ok3_q  <= dn_q != '0;
      neg3_q <= {nx_q[SB-1] ^ dn_q[SB-1], ny_q[SB-1] ^ dn_q[SB-1]};
      pay3_q <= pay2_q;
    end
  end

  // Division chain, one quotient bit per stage.
  logic          dv  [NDS+1];
  logic          dok [NDS+1];
  logic [SB-1:0] dad [NDS+1];
  logic [SB-1:0] dnx [NDS+1];
  logic [SB-1:0] dny [NDS+1];
  logic [SB:0]   drx [NDS+1];
  logic [SB:0]   dry [NDS+1];
  logic [QB-1:0] dqx [NDS+1];
  logic [QB-1:0] dqy [NDS+1];
  logic [1:0]    dng [NDS+1];
  logic [PB-1:0] dpy [NDS+1];

  assign dv[0]  = v3_q;
  assign dok[0] = ok3_q;
  assign dad[0] = ad_q;
  assign dnx[0] = anx_q;
  assign dny[0] = any_q;
  assign drx[0] = '0;
  assign dry[0] = '0;
  assign dqx[0] = '0;
  assign dqy[0] = '0;
  assign dng[0] = neg3_q;
  assign dpy[0] = pay3_q;

  for (genvar g = 0; g < NDS; g++) begin : g_div
    hic_div_stage #(.PayBits(PB), .Step(NDS - 1 - g)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[g]), .ok_i(dok[g]), .ad_i(dad[g]),
      .anx_i(dnx[g]), .any_i(dny[g]), .remx_i(drx[g]), .remy_i(dry[g]),
      .quox_i(dqx[g]), .quoy_i(dqy[g]), .neg_i(dng[g]), .pay_i(dpy[g]),
      .valid_o(dv[g+1]), .ok_o(dok[g+1]), .ad_o(dad[g+1]),
      .anx_o(dnx[g+1]), .any_o(dny[g+1]), .remx_o(drx[g+1]), .remy_o(dry[g+1]),
      .quox_o(dqx[g+1]), .quoy_o(dqy[g+1]), .neg_o(dng[g+1]), .pay_o(dpy[g+1])
    );
  end

  // Compare stage A: signed errors and per-axis bound.
  localparam int unsigned EB = QB + 2;
  logic signed [EB-1:0] qx, qy, dx, dy, ex, ey, mep, men;
  logic                 inx, iny;
  logic                 va_q, oka_q;
  logic [15:0]          aex_q, aey_q, me_q;
  logic [PB-1:0]        paya_q;

  always_comb begin
    qx  = $signed(EB'(dqx[NDS]));
    qy  = $signed(EB'(dqy[NDS]));
    dx  = EB'($signed(dpy[NDS][2*CB-1:CB]));
    dy  = EB'($signed(dpy[NDS][CB-1:0]));
    // A negative projection flips the error sign; bound and square ignore it.
    ex  = dng[NDS][1] ? qx + dx : qx - dx;
    ey  = dng[NDS][0] ? qy + dy : qy - dy;
    mep = $signed(EB'(max_error_q));
    men = -mep;
    inx = (ex <= mep) & (ex >= men);
    iny = (ey <= mep) & (ey >= men);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= dv[NDS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oka_q  <= dok[NDS] & inx & iny;
      aex_q  <= ex[EB-1] ? 16'(-ex[15:0]) : ex[15:0];
      aey_q  <= ey[EB-1] ? 16'(-ey[15:0]) : ey[15:0];
      me_q   <= max_error_q;
      paya_q <= dpy[NDS];
    end
  end

  // Compare stage B: squares.
  logic          vb_q, okb_q;
  logic [31:0]   sx_q, sy_q, lim_q;
  logic [PB-1:0] payb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      okb_q  <= oka_q;
      sx_q   <= aex_q * aex_q;
      sy_q   <= aey_q * aey_q;
      lim_q  <= me_q * me_q;
      payb_q <= paya_q;
    end
  end

  // Output register: hold only inliers.
  logic [PB-1:0] out_q;
  logic          keep;
  assign keep = vb_q & okb_q & ({1'b0, sx_q} + {1'b0, sy_q} <= {1'b0, lim_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= keep;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= payb_q;
  end

  assign out_valid_o = out_valid_q;
  assign in_src_x_o  = out_q[4*CB-1:3*CB];
  assign in_src_y_o  = out_q[3*CB-1:2*CB];
  assign in_dst_x_o  = out_q[2*CB-1:CB];
  assign in_dst_y_o  = out_q[CB-1:0];

endmodule

// ----- test/tb_homography_inlier_check_unit.sv -----
// Testbench for the homography inlier check unit: directed table and random pairs vs. predictor.
`timescale 1ns / 100ps

module tb_homography_inlier_check_unit;

  localparam int unsigned CoordBits = 20;
  localparam int unsigned CoefBits  = 21;
  localparam int unsigned RegBits   = hic_pkg::RegBits;
  localparam int unsigned ErrBits   = hic_pkg::ErrBits;
  localparam int unsigned IdxBits   = hic_pkg::IdxBits;
  localparam longint      CoordMax  = 524287;
  localparam longint      CoordMin  = -524288;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainWait = 100;
  localparam int unsigned HoldLen   = 400;

  // How the expected outcome of a directed row is known.
  localparam int unsigned KindReject  = 0;
  localparam int unsigned KindAccept  = 1;
  localparam int unsigned KindPredict = 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct {
    coord_t sx, sy, dx, dy;
  } pair_t;

  typedef struct {
    logic [RegBits-1:0] r1, r2, r3;
    logic [ErrBits-1:0] me;
  } hcfg_t;

  typedef struct {
    int unsigned cset;
    coord_t      sx, sy, dx, dy;
    int unsigned kind;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [IdxBits-1:0] cfg_idx_i   = '0;
  logic [RegBits-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  coord_t             src_x_i     = '0;
  coord_t             src_y_i     = '0;
  coord_t             dst_x_i     = '0;
  coord_t             dst_y_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  coord_t             in_src_x_o, in_src_y_o, in_dst_x_o, in_dst_y_o;

  homography_inlier_check_unit #(
    .COORD_BITS(CoordBits),
    .COEF_BITS (CoefBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .src_x_i    (src_x_i),
    .src_y_i    (src_y_i),
    .dst_x_i    (dst_x_i),
    .dst_y_i    (dst_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .in_src_x_o (in_src_x_o),
    .in_src_y_o (in_src_y_o),
    .in_dst_x_o (in_dst_x_o),
    .in_dst_y_o (in_dst_y_o)
  );

  always #5 clk_i = ~clk_i;

  // Current homography and threshold as seen by the predictor.
  logic [RegBits-1:0] h_row1 = '0;
  logic [RegBits-1:0] h_row2 = '0;
  logic [RegBits-1:0] h_row3 = '0;
  logic [ErrBits-1:0] err_lim = hic_pkg::MaxErrorReset;

  pair_t       inlier_q[$];
  int unsigned err_cnt   = 0;
  int unsigned snd_idle  = 0;
  int unsigned rcv_idle  = 0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cyc  = 0;

  hcfg_t dir_cfg[6];
  row_t  dir_rows[$];

  function automatic longint coef_at(logic [RegBits-1:0] r, int unsigned k);
    logic signed [CoefBits-1:0] c;
    c = r[k*CoefBits +: CoefBits];
    return longint'(c);
  endfunction

  // Truncating n * 2^18 / d; fails on a zero divisor or a quotient of 2^50 or more.
  function automatic bit scaled_quot(longint n, longint d, output longint q);
    logic [127:0] an, ad, qq;
    q = 0;
    if (d == 0) return 1'b0;
    an = (n < 0) ? 128'(-n) : 128'(n);
    ad = (d < 0) ? 128'(-d) : 128'(d);
    qq = (an << hic_pkg::QuotShift) / ad;
    if (qq >= (128'd1 << 50)) return 1'b0;
    q = ((n < 0) != (d < 0)) ? -longint'(qq) : longint'(qq);
    return 1'b1;
  endfunction

  function automatic bit project_src(coord_t sx, coord_t sy, output longint px, output longint py);
    longint nx, ny, den, x, y;
    x   = longint'(sx);
    y   = longint'(sy);
    nx  = coef_at(h_row1, 0) * x + coef_at(h_row1, 1) * y + coef_at(h_row1, 2) * 65536;
    ny  = coef_at(h_row2, 0) * x + coef_at(h_row2, 1) * y + coef_at(h_row2, 2) * 65536;
    den = coef_at(h_row3, 0) * x + coef_at(h_row3, 1) * y + coef_at(h_row3, 2) * 262144;
    py  = 0;
    if (!scaled_quot(nx, den, px)) return 1'b0;
    return scaled_quot(ny, den, py);
  endfunction

  function automatic bit predict_inlier(pair_t p);
    longint px, py, ex, ey, me;
    if (!project_src(p.sx, p.sy, px, py)) return 1'b0;
    ex = px - longint'(p.dx);
    ey = py - longint'(p.dy);
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    me = longint'(err_lim);
    if (ex > me || ey > me) return 1'b0;
    return (ex * ex + ey * ey) <= me * me;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic int rand_pm(int unsigned m);
    return int'($urandom_range(0, 2 * m)) - int'(m);
  endfunction

  function automatic void add_row(int unsigned cs, coord_t sx, coord_t sy,
                                  coord_t dx, coord_t dy, int unsigned kind);
    row_t r;
    r = '{cs, sx, sy, dx, dy, kind};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Drop valid, wait for every expected pair, then let the pipeline empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (inlier_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_config(hcfg_t c);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= hic_pkg::RegRowOne;   cfg_data_i <= c.r1;
    @(posedge clk_i);
    cfg_idx_i <= hic_pkg::RegRowTwo;   cfg_data_i <= c.r2;
    @(posedge clk_i);
    cfg_idx_i <= hic_pkg::RegRowThree; cfg_data_i <= c.r3;
    @(posedge clk_i);
    cfg_idx_i <= hic_pkg::RegMaxError; cfg_data_i <= RegBits'(c.me);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    h_row1 = c.r1; h_row2 = c.r2; h_row3 = c.r3; err_lim = c.me;
  endtask

  task automatic send_pair(pair_t p, int unsigned kind);
    bit hs;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid_i <= 1'b1;
    src_x_i <= p.sx; src_y_i <= p.sy; dst_x_i <= p.dx; dst_y_i <= p.dy;
    forever begin
      @(negedge clk_i);
      hs = in_ready_o;
      @(posedge clk_i);
      if (hs) break;
    end
    if (kind == KindAccept || (kind == KindPredict && predict_inlier(p))) begin
      inlier_q.insert(inlier_q.size(), p);
    end
  endtask

  function automatic hcfg_t rand_homography(int unsigned shape, logic [ErrBits-1:0] me);
    hcfg_t c;
    logic [CoefBits-1:0] a, b, t;
    c.me = me;
    case (shape)
      0: begin
        a = CoefBits'(65536 + rand_pm(4096)); b = CoefBits'(rand_pm(4096));
        t = CoefBits'($urandom);
        c.r1 = {t, b, a};
        a = CoefBits'(65536 + rand_pm(4096)); b = CoefBits'(rand_pm(4096));
        t = CoefBits'($urandom);
        c.r2 = {t, a, b};
        c.r3 = {CoefBits'(65536 + rand_pm(4096)), CoefBits'(rand_pm(64)), CoefBits'(rand_pm(64))};
      end
      1: begin
        c.r1 = RegBits'({$urandom, $urandom});
        c.r2 = RegBits'({$urandom, $urandom});
        c.r3 = RegBits'({$urandom, $urandom});
      end
      default: begin
        c.r1 = {3{21'h100000}};
        c.r2 = {3{21'h1FFFFF}};
        c.r3 = {3{21'h0FFFFF}};
      end
    endcase
    return c;
  endfunction

  // Receiver: random stalls, plus one long hold requested by the stimulus.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Check each accepted result against the oldest expected pair.
  initial begin
    pair_t got, want;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{in_src_x_o, in_src_y_o, in_dst_x_o, in_dst_y_o};
        if (inlier_q.size() == 0) begin
          $display("%0t: unexpected pair expected none actual %p", $realtime, got);
          err_cnt++;
        end else begin
          want = inlier_q.pop_front();
          if (got.sx !== want.sx) begin
            $display("%0t: in_src_x expected %0d actual %0d", $realtime, want.sx, got.sx);
            err_cnt++;
          end
          if (got.sy !== want.sy) begin
            $display("%0t: in_src_y expected %0d actual %0d", $realtime, want.sy, got.sy);
            err_cnt++;
          end
          if (got.dx !== want.dx) begin
            $display("%0t: in_dst_x expected %0d actual %0d", $realtime, want.dx, got.dx);
            err_cnt++;
          end
          if (got.dy !== want.dy) begin
            $display("%0t: in_dst_y expected %0d actual %0d", $realtime, want.dy, got.dy);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any request moving on either side.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    pair_t       p;
    hcfg_t       c;
    int unsigned cur_set;
    int unsigned ph, n, shape, spread;
    longint      px, py;
    logic [ErrBits-1:0] me;

    // Configuration sets of the directed part; set zero is the reset state.
    dir_cfg[0] = '{'0, '0, '0, hic_pkg::MaxErrorReset};
    dir_cfg[1] = '{{21'd0, 21'd0, 21'd65536}, {21'd0, 21'd65536, 21'd0},
                   {21'd65536, 21'd0, 21'd0}, 16'd64};
    dir_cfg[2] = dir_cfg[1];
    dir_cfg[2].me = 16'd0;
    dir_cfg[3] = '{{21'hFFFFF, 21'd0, 21'd0}, '0, {21'd0, 21'd0, 21'd1}, 16'd64};
    dir_cfg[4] = '{{21'd0, 21'd0, 21'h1F0000}, {21'd0, 21'h1F0000, 21'd0},
                   {21'h1F0000, 21'd0, 21'd0}, 16'd64};
    dir_cfg[5] = dir_cfg[1];
    dir_cfg[5].me = 16'hFFFF;

    // Zero coefficients after reset: all rejected.
    add_row(0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, KindReject);
    add_row(0, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, KindReject);
    add_row(0, 0, 0, 0, 0, KindReject);
    // Identity, threshold 64: the boundary sits exactly at an error of 64.
    add_row(1, 0, 0, 0, 0, KindAccept);
    add_row(1, 100, -200, 100, -200, KindAccept);
    add_row(1, 0, 0, 64, 0, KindAccept);
    add_row(1, 0, 0, 65, 0, KindReject);
    add_row(1, 0, 0, 0, -64, KindAccept);
    add_row(1, 0, 0, 46, 46, KindPredict);
    add_row(1, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, KindAccept);
    add_row(1, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, KindAccept);
    add_row(1, 20'sh80000, 0, 20'sh7FFFF, 0, KindReject);
    // Zero threshold: only an exact hit passes.
    add_row(2, 5, 5, 5, 5, KindAccept);
    add_row(2, 5, 5, 6, 5, KindReject);
    // Tiny denominator: huge projection, and zero denominator.
    add_row(3, 1, 0, 0, 0, KindReject);
    add_row(3, -1, 0, 0, 0, KindReject);
    add_row(3, 0, 0, 0, 0, KindReject);
    // Negated homography: negative denominator, same projection.
    add_row(4, 300, -7, 300, -7, KindAccept);
    add_row(4, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000, KindAccept);
    // Largest threshold.
    add_row(5, 0, 0, 65535, 0, KindAccept);
    add_row(5, 0, 0, 65536, 0, KindReject);
    add_row(5, 0, 0, 40000, 40000, KindPredict);
    add_row(5, 20'sh12345, -77, 20'sh22345, 20'sh7FF00, KindPredict);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    snd_idle = 29; rcv_idle = 61;
    cur_set = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cset != cur_set) begin
        cur_set = dir_rows[i].cset;
        load_config(dir_cfg[cur_set]);
      end
      p = '{dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].dx, dir_rows[i].dy};
      send_pair(p, dir_rows[i].kind);
    end

    // Random phases: a fresh homography and threshold each.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0, 1: begin snd_idle = 29; rcv_idle = 61; end
        2, 3: begin snd_idle = 61; rcv_idle = 29; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      case (ph)
        0: me = 16'd64;
        1: me = 16'd0;
        3: me = 16'hFFFF;
        4: me = 16'd200;
        6: me = 16'd1000;
        default: me = ErrBits'($urandom_range(1, 2000));
      endcase
      shape = (ph == 2) ? 1 : (ph == 4) ? 2 : 0;
      c = rand_homography(shape, me);
      load_config(c);
      spread = int'(me) + int'(me) / 4 + 2;
      for (n = 0; n < 150; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 70) begin
          if ($urandom_range(0, 1)) begin
            p.sx = coord_t'(rand_pm(4096));
            p.sy = coord_t'(rand_pm(4096));
          end else begin
            p.sx = coord_t'($urandom); p.sy = coord_t'($urandom);
          end
          if (project_src(p.sx, p.sy, px, py) && px <= CoordMax && px >= CoordMin
              && py <= CoordMax && py >= CoordMin) begin
            p.dx = coord_t'(clamp_coord(px + rand_pm(spread)));
            p.dy = coord_t'(clamp_coord(py + rand_pm(spread)));
          end else begin
            p.dx = coord_t'($urandom); p.dy = coord_t'($urandom);
          end
        end else begin
          p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
        end
        send_pair(p, KindPredict);
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
